[rtl/arcl_pkg.sv]
// Package for the address resolution cache with LRU replacement.
// Holds sizes, field widths, action codes and register indexes.
// Used by rtl/address_resolution_cache_lru_unit.sv; depends on nothing.
package arcl_pkg;

    localparam int ENTRIES    = 16;
    localparam int STAMP_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);

    localparam int NET_W  = 16;
    localparam int LINK_W = 48;
    localparam int ACT_W  = 3;
    localparam int CFG_W  = 48;
    localparam int CIDX_W = 2;

    localparam logic [ACT_W-1:0] ACT_DROP        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPLY       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEND_CACHED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BROADCAST   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REQUEST     = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_MY_NET     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PROTO_TYPE = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_ARP_DIS    = 2'd3;

    localparam logic [15:0]       HW_TYPE_ETH    = 16'd1;
    localparam logic [7:0]        HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]        PROTO_LEN_NET  = 8'd2;
    localparam logic [15:0]       OP_REQUEST     = 16'd1;
    localparam logic [15:0]       PROTO_RESET    = 16'd2052;
    localparam logic [LINK_W-1:0] LINK_BCAST     = {LINK_W{1'b1}};

endpackage

[rtl/address_resolution_cache_lru_unit.sv]
// Address resolution cache: table of network to link address mappings with LRU refill.
// Scans the table one slot per cycle under a small sequencer.
// Depends on rtl/arcl_pkg.sv.
//
// Usage:
// The input channel (i_valid, o_stall) carries one beat per lookup: either an
// incoming ARP packet (i_func low) or a transmit destination (i_func high).
// The output channel (o_valid, i_stall) returns exactly one result beat per
// input beat. Configuration is written through i_cfg_wr_en, i_cfg_index and
// i_cfg_wdata only while the block is idle, a rule for the user that the block
// itself does not enforce; index 1 (own link address) is accepted and has no
// effect on the results. A beat dropped by validation or a broadcast transmit
// has its result registered directly on acceptance. Otherwise the sequencer
// scans the table (1 to ENTRIES slots visited), then moves to S_FINISH, which
// registers the result and applies any table update. The block handles one
// beat at a time; o_stall is high from acceptance until the result beat is
// taken, so no new beat is accepted before then.
// While i_stall is high the result beat is held unchanged.
// Reset empties the table, clears all stamps, sets the use clock to one and
// loads register reset values; no clearing pass is needed.
module address_resolution_cache_lru_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [arcl_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [arcl_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic [15:0]                         i_hw_type,
    input  logic [15:0]                         i_proto_type,
    input  logic [7:0]                          i_hw_len,
    input  logic [7:0]                          i_proto_len,
    input  logic [15:0]                         i_arp_opcode,
    input  logic [arcl_pkg::LINK_W-1:0]         i_sender_link_addr,
    input  logic [arcl_pkg::NET_W-1:0]          i_sender_net_addr,
    input  logic [arcl_pkg::NET_W-1:0]          i_target_net_addr,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [arcl_pkg::ACT_W-1:0]          o_action,
    output logic [arcl_pkg::LINK_W-1:0]         o_frame_dest_link,
    output logic [arcl_pkg::LINK_W-1:0]         o_arp_target_link,
    output logic [arcl_pkg::NET_W-1:0]          o_arp_target_net,
    output logic                                o_cache_hit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    t_state r_state;

    logic [arcl_pkg::NET_W-1:0]      r_my_net;
    logic [15:0]                     r_proto;
    logic                            r_arp_dis;

    logic [arcl_pkg::NET_W-1:0]      r_net   [arcl_pkg::ENTRIES];
    logic [arcl_pkg::STAMP_BITS-1:0] r_stamp [arcl_pkg::ENTRIES];
    logic [arcl_pkg::LINK_W-1:0]     r_link_mem [arcl_pkg::ENTRIES];
    logic [arcl_pkg::LINK_W-1:0]     r_link_q;
    logic [arcl_pkg::STAMP_BITS-1:0] r_use_clock;

    logic                            r_func;
    logic                            r_req;
    logic [arcl_pkg::LINK_W-1:0]     r_s_link;
    logic [arcl_pkg::NET_W-1:0]      r_s_net;
    logic [arcl_pkg::NET_W-1:0]      r_t_net;

    logic [arcl_pkg::IDX_W-1:0]      r_idx;
    logic [arcl_pkg::IDX_W-1:0]      r_vic;
    logic [arcl_pkg::STAMP_BITS-1:0] r_vic_stamp;
    logic                            r_hit;

    logic                            in_accept;
    logic                            in_ok;
    logic [arcl_pkg::NET_W-1:0]      cur_net;
    logic [arcl_pkg::STAMP_BITS-1:0] cur_stamp;
    logic                            is_last;
    logic                            older;
    logic [arcl_pkg::STAMP_BITS-1:0] n_use_clock;
    logic                            to_me;
    logic                            link_we;
    logic [arcl_pkg::IDX_W-1:0]      link_waddr;

    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && !o_stall;
    assign cur_net     = r_net[r_idx];
    assign cur_stamp   = r_stamp[r_idx];
    assign is_last     = (r_idx == arcl_pkg::IDX_W'(arcl_pkg::ENTRIES - 1));
    assign older       = (cur_stamp < r_vic_stamp);
    assign n_use_clock = r_use_clock + arcl_pkg::STAMP_BITS'(1);
    assign to_me       = (r_t_net == r_my_net);
    assign link_we     = (r_state == S_FINISH) && !r_func && (r_hit || to_me);
    assign link_waddr  = r_hit ? r_idx : r_vic;

    assign in_ok = (i_hw_type == arcl_pkg::HW_TYPE_ETH) && (i_proto_type == r_proto)
                && (i_hw_len == arcl_pkg::HW_LEN_ETH) && (i_proto_len == arcl_pkg::PROTO_LEN_NET)
                && !r_arp_dis && (i_sender_net_addr != '0) && (i_target_net_addr != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_net  <= '0;
            r_proto   <= arcl_pkg::PROTO_RESET;
            r_arp_dis <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                arcl_pkg::CFG_MY_NET:     r_my_net  <= i_cfg_wdata[arcl_pkg::NET_W-1:0];
                arcl_pkg::CFG_PROTO_TYPE: r_proto   <= i_cfg_wdata[15:0];
                arcl_pkg::CFG_ARP_DIS:    r_arp_dis <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= r_s_link;
        end
        r_link_q <= r_link_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_use_clock <= arcl_pkg::STAMP_BITS'(1);
            r_idx       <= '0;
            r_hit       <= 1'b0;
            for (int i = 0; i < arcl_pkg::ENTRIES; i++) begin
                r_net[i]   <= '0;
                r_stamp[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_func      <= i_func;
                        r_req       <= (i_arp_opcode == arcl_pkg::OP_REQUEST);
                        r_s_link    <= i_sender_link_addr;
                        r_s_net     <= i_sender_net_addr;
                        r_t_net     <= i_target_net_addr;
                        r_idx       <= '0;
                        r_vic       <= '0;
                        r_vic_stamp <= r_stamp[0];
                        r_hit       <= 1'b0;
                        if (!i_func && !in_ok) begin
                            o_action          <= arcl_pkg::ACT_DROP;
                            o_frame_dest_link <= '0;
                            o_arp_target_link <= '0;
                            o_arp_target_net  <= '0;
                            o_cache_hit       <= 1'b0;
                            o_valid           <= 1'b1;
                            r_state           <= S_DONE;
                        end else if (i_func && (i_target_net_addr == '0)) begin
                            o_action          <= arcl_pkg::ACT_BROADCAST;
                            o_frame_dest_link <= arcl_pkg::LINK_BCAST;
                            o_arp_target_link <= '0;
                            o_arp_target_net  <= '0;
                            o_cache_hit       <= 1'b0;
                            o_valid           <= 1'b1;
                            r_state           <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_func) begin
                        if (cur_net == '0) begin
                            r_state <= S_FINISH;
                        end else if (cur_net == r_t_net) begin
                            r_hit   <= 1'b1;
                            r_state <= S_FINISH;
                        end else if (is_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        if (cur_net == r_s_net) begin
                            r_hit   <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            if (older) begin
                                r_vic       <= r_idx;
                                r_vic_stamp <= cur_stamp;
                            end
                            if ((older && (cur_net == '0)) || is_last) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_FINISH: begin
                    o_valid     <= 1'b1;
                    r_state     <= S_DONE;
                    o_cache_hit <= r_hit;
                    if (r_func && r_hit) begin
                        r_use_clock       <= n_use_clock;
                        r_stamp[r_idx]    <= n_use_clock;
                        o_action          <= arcl_pkg::ACT_SEND_CACHED;
                        o_frame_dest_link <= r_link_q;
                        o_arp_target_link <= '0;
                        o_arp_target_net  <= '0;
                    end else if (r_func) begin
                        o_action          <= arcl_pkg::ACT_REQUEST;
                        o_frame_dest_link <= arcl_pkg::LINK_BCAST;
                        o_arp_target_link <= arcl_pkg::LINK_BCAST;
                        o_arp_target_net  <= r_t_net;
                    end else begin
                        if (to_me && !r_hit) begin
                            r_net[r_vic]   <= r_s_net;
                            r_stamp[r_vic] <= arcl_pkg::STAMP_BITS'(1);
                        end
                        if (to_me && r_req) begin
                            o_action          <= arcl_pkg::ACT_REPLY;
                            o_frame_dest_link <= r_s_link;
                            o_arp_target_link <= r_s_link;
                            o_arp_target_net  <= r_s_net;
                        end else begin
                            o_action          <= arcl_pkg::ACT_DROP;
                            o_frame_dest_link <= '0;
                            o_arp_target_link <= '0;
                            o_arp_target_net  <= '0;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_stall)
        else $error("Block took a beat and did not become busy.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("Input accepted while a result is pending.");

    a_cached_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == arcl_pkg::ACT_SEND_CACHED) |-> o_cache_hit)
        else $error("Cached send without a table hit.");

    a_request_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == arcl_pkg::ACT_REQUEST)
        |-> !o_cache_hit && (o_frame_dest_link == arcl_pkg::LINK_BCAST)
            && (o_arp_target_net != '0))
        else $error("ARP request result is inconsistent.");

endmodule

[tb/address_resolution_cache_lru_unit_test.sv]
// Self-checking testbench for address_resolution_cache_lru_unit.
// Drives directed and random ARP and transmit beats, with and without random pacing, and predicts each result
// from its own cache copy. Depends on rtl/arcl_pkg.sv and rtl/address_resolution_cache_lru_unit.sv.
`timescale 1ns / 100ps

module address_resolution_cache_lru_unit_test;

    localparam logic [arcl_pkg::CIDX_W-1:0]     CFG_MY_LINK = 2'd1;
    localparam logic                            FUNC_ARP_IN = 1'b0;
    localparam logic                            FUNC_XMIT   = 1'b1;
    localparam logic [15:0]                     OP_REPLY    = 16'd2;
    localparam logic [arcl_pkg::STAMP_BITS-1:0] FRESH_STAMP = arcl_pkg::STAMP_BITS'(1);
    localparam int POOL_SIZE   = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                        func;
        logic [15:0]                 hw_type;
        logic [15:0]                 proto_type;
        logic [7:0]                  hw_len;
        logic [7:0]                  proto_len;
        logic [15:0]                 arp_opcode;
        logic [arcl_pkg::LINK_W-1:0] sender_link;
        logic [arcl_pkg::NET_W-1:0]  sender_net;
        logic [arcl_pkg::NET_W-1:0]  target_net;
    } t_arp_beat;

    typedef struct packed {
        logic [arcl_pkg::ACT_W-1:0]  action;
        logic [arcl_pkg::LINK_W-1:0] frame_dest;
        logic [arcl_pkg::LINK_W-1:0] target_link;
        logic [arcl_pkg::NET_W-1:0]  target_net;
        logic                        cache_hit;
    } t_arcl_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [arcl_pkg::CIDX_W-1:0] i_cfg_index = '0;
    logic [arcl_pkg::CFG_W-1:0]  i_cfg_wdata = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic                        i_func = 1'b0;
    logic [15:0]                 i_hw_type = '0;
    logic [15:0]                 i_proto_type = '0;
    logic [7:0]                  i_hw_len = '0;
    logic [7:0]                  i_proto_len = '0;
    logic [15:0]                 i_arp_opcode = '0;
    logic [arcl_pkg::LINK_W-1:0] i_sender_link_addr = '0;
    logic [arcl_pkg::NET_W-1:0]  i_sender_net_addr = '0;
    logic [arcl_pkg::NET_W-1:0]  i_target_net_addr = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [arcl_pkg::ACT_W-1:0]  o_action;
    logic [arcl_pkg::LINK_W-1:0] o_frame_dest_link;
    logic [arcl_pkg::LINK_W-1:0] o_arp_target_link;
    logic [arcl_pkg::NET_W-1:0]  o_arp_target_net;
    logic                        o_cache_hit;

    logic [arcl_pkg::NET_W-1:0]      cache_net [arcl_pkg::ENTRIES];
    logic [arcl_pkg::LINK_W-1:0]     cache_link [arcl_pkg::ENTRIES];
    logic [arcl_pkg::STAMP_BITS-1:0] cache_stamp [arcl_pkg::ENTRIES];
    logic [arcl_pkg::STAMP_BITS-1:0] use_count;
    logic [arcl_pkg::NET_W-1:0]      cfg_my_net = '0;
    logic [15:0]                     cfg_proto = arcl_pkg::PROTO_RESET;
    logic                            cfg_arp_dis = 1'b0;

    logic [arcl_pkg::NET_W-1:0] net_pool [POOL_SIZE];
    t_arcl_result     awaited_results [$];
    int               mismatch_count = 0;
    bit               tx_pacing_on = 1'b1;
    bit               rx_pacing_on = 1'b1;
    int               rx_hold_cycles = 0;

    address_resolution_cache_lru_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_hw_type          (i_hw_type),
        .i_proto_type       (i_proto_type),
        .i_hw_len           (i_hw_len),
        .i_proto_len        (i_proto_len),
        .i_arp_opcode       (i_arp_opcode),
        .i_sender_link_addr (i_sender_link_addr),
        .i_sender_net_addr  (i_sender_net_addr),
        .i_target_net_addr  (i_target_net_addr),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_action           (o_action),
        .o_frame_dest_link  (o_frame_dest_link),
        .o_arp_target_link  (o_arp_target_link),
        .o_arp_target_net   (o_arp_target_net),
        .o_cache_hit        (o_cache_hit)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [arcl_pkg::LINK_W-1:0] rand_link();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[arcl_pkg::LINK_W-1:0];
    endfunction

    function automatic logic [arcl_pkg::NET_W-1:0] nonzero_net();
        return arcl_pkg::NET_W'($urandom_range(1, 16'hFFFF));
    endfunction

    function automatic logic [arcl_pkg::NET_W-1:0] pool_addr();
        return net_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_arp_beat noise_beat();
        t_arp_beat b;
        b.func        = 1'($urandom_range(0, 1));
        b.hw_type     = 16'($urandom);
        b.proto_type  = 16'($urandom);
        b.hw_len      = 8'($urandom);
        b.proto_len   = 8'($urandom);
        b.arp_opcode  = 16'($urandom);
        b.sender_link = rand_link();
        b.sender_net  = arcl_pkg::NET_W'($urandom);
        b.target_net  = arcl_pkg::NET_W'($urandom);
        return b;
    endfunction

    function automatic t_arp_beat make_arp(input logic [arcl_pkg::LINK_W-1:0] link,
                                           input logic [arcl_pkg::NET_W-1:0] snet,
                                           input logic [arcl_pkg::NET_W-1:0] tnet,
                                           input logic [15:0] op);
        t_arp_beat b;
        b.func        = FUNC_ARP_IN;
        b.hw_type     = arcl_pkg::HW_TYPE_ETH;
        b.proto_type  = cfg_proto;
        b.hw_len      = arcl_pkg::HW_LEN_ETH;
        b.proto_len   = arcl_pkg::PROTO_LEN_NET;
        b.arp_opcode  = op;
        b.sender_link = link;
        b.sender_net  = snet;
        b.target_net  = tnet;
        return b;
    endfunction

    function automatic t_arp_beat make_xmit(input logic [arcl_pkg::NET_W-1:0] dest);
        t_arp_beat b;
        b = noise_beat();
        b.func = FUNC_XMIT;
        b.target_net = dest;
        return b;
    endfunction

    function automatic t_arcl_result resolve_beat(input t_arp_beat b);
        t_arcl_result r;
        int slot;
        int victim;
        bit found;
        bit stop;
        r = '0;
        r.action = arcl_pkg::ACT_DROP;
        slot = 0;
        victim = 0;
        found = 1'b0;
        stop = 1'b0;
        if (b.func == FUNC_XMIT) begin
            if (b.target_net == '0) begin
                r.action = arcl_pkg::ACT_BROADCAST;
                r.frame_dest = arcl_pkg::LINK_BCAST;
                return r;
            end
            for (int i = 0; i < arcl_pkg::ENTRIES && !found && cache_net[i] != '0; i++) begin
                if (cache_net[i] == b.target_net) begin
                    found = 1'b1;
                    slot = i;
                end
            end
            if (found) begin
                use_count = use_count + 1'b1;
                cache_stamp[slot] = use_count;
                r.action = arcl_pkg::ACT_SEND_CACHED;
                r.frame_dest = cache_link[slot];
                r.cache_hit = 1'b1;
            end else begin
                r.action = arcl_pkg::ACT_REQUEST;
                r.frame_dest = arcl_pkg::LINK_BCAST;
                r.target_link = arcl_pkg::LINK_BCAST;
                r.target_net = b.target_net;
            end
            return r;
        end
        if (b.hw_type != arcl_pkg::HW_TYPE_ETH || b.proto_type != cfg_proto
                || b.hw_len != arcl_pkg::HW_LEN_ETH
                || b.proto_len != arcl_pkg::PROTO_LEN_NET || cfg_arp_dis
                || b.sender_net == '0 || b.target_net == '0)
            return r;
        for (int i = 0; i < arcl_pkg::ENTRIES && !stop; i++) begin
            if (cache_net[i] == b.sender_net) begin
                found = 1'b1;
                slot = i;
                stop = 1'b1;
            end else if (cache_stamp[i] < cache_stamp[victim]) begin
                victim = i;
                if (cache_net[i] == '0) stop = 1'b1;
            end
        end
        if (found) cache_link[slot] = b.sender_link;
        r.cache_hit = found;
        if (b.target_net != cfg_my_net) return r;
        if (!found) begin
            cache_link[victim]  = b.sender_link;
            cache_net[victim]   = b.sender_net;
            cache_stamp[victim] = FRESH_STAMP;
        end
        if (b.arp_opcode == arcl_pkg::OP_REQUEST) begin
            r.action = arcl_pkg::ACT_REPLY;
            r.frame_dest = b.sender_link;
            r.target_link = b.sender_link;
            r.target_net = b.sender_net;
        end
        return r;
    endfunction

    function automatic t_arp_beat random_beat();
        t_arp_beat b;
        int pick;
        logic [15:0] op;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) op = arcl_pkg::OP_REQUEST;
        else if ($urandom_range(0, 1) != 0) op = OP_REPLY;
        else op = 16'($urandom);
        if (pick < 30) begin
            b = make_arp(rand_link(), pool_addr(), cfg_my_net, op);
        end else if (pick < 45) begin
            b = make_arp(rand_link(), pool_addr(),
                         ($urandom_range(0, 1) != 0) ? pool_addr() : nonzero_net(), op);
        end else if (pick < 75) begin
            b = make_xmit(pool_addr());
            if ($urandom_range(0, 19) == 0) b.target_net = '0;
            else if ($urandom_range(0, 19) == 0) b.target_net = arcl_pkg::NET_W'($urandom);
        end else begin
            b = make_arp(rand_link(), pool_addr(), cfg_my_net, op);
            case ($urandom_range(0, 7))
                0: b.hw_type = 16'($urandom);
                1: b.proto_type = 16'($urandom);
                2: b.hw_len = 8'($urandom);
                3: b.proto_len = 8'($urandom);
                4: b.sender_net = '0;
                5: b.target_net = '0;
                6: b.sender_net = arcl_pkg::NET_W'($urandom);
                default: b = noise_beat();
            endcase
        end
        return b;
    endfunction

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            if (net_pool[i] == '0 || $urandom_range(0, 1) != 0) net_pool[i] = nonzero_net();
    endtask

    task automatic send_beat(input t_arp_beat b);
        int gap;
        gap = tx_pacing_on ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func             <= b.func;
        i_hw_type          <= b.hw_type;
        i_proto_type       <= b.proto_type;
        i_hw_len           <= b.hw_len;
        i_proto_len        <= b.proto_len;
        i_arp_opcode       <= b.arp_opcode;
        i_sender_link_addr <= b.sender_link;
        i_sender_net_addr  <= b.sender_net;
        i_target_net_addr  <= b.target_net;
        i_valid            <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        awaited_results.push_back(resolve_beat(b));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [arcl_pkg::CIDX_W-1:0] idx,
                             input logic [arcl_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            arcl_pkg::CFG_MY_NET:     cfg_my_net = value[arcl_pkg::NET_W-1:0];
            arcl_pkg::CFG_PROTO_TYPE: cfg_proto = value[15:0];
            arcl_pkg::CFG_ARP_DIS:    cfg_arp_dis = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [arcl_pkg::NET_W-1:0] net,
                                  input logic [arcl_pkg::LINK_W-1:0] link,
                                  input logic [15:0] proto, input logic dis);
        wait_idle();
        write_reg(arcl_pkg::CFG_MY_NET, arcl_pkg::CFG_W'(net));
        write_reg(CFG_MY_LINK, link);
        write_reg(arcl_pkg::CFG_PROTO_TYPE, arcl_pkg::CFG_W'(proto));
        write_reg(arcl_pkg::CFG_ARP_DIS, arcl_pkg::CFG_W'(dis));
    endtask

    task automatic test_directed_cases();
        t_arp_beat good;
        t_arp_beat b;
        apply_settings(16'h1234, 48'h0200_0000_0001, 16'h0800, 1'b0);
        send_beat(make_xmit(16'h0000));
        send_beat(make_xmit(16'hFFFF));
        send_beat(make_arp(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'h1234, arcl_pkg::OP_REQUEST));
        send_beat(make_xmit(16'hFFFF));
        send_beat(make_arp(48'h0, 16'h0001, 16'h1234, OP_REPLY));
        send_beat(make_arp(48'h0000_0000_0001, 16'hFFFF, 16'h4321, arcl_pkg::OP_REQUEST));
        send_beat(make_xmit(16'hFFFF));
        send_beat(make_arp(48'hA5A5_5A5A_C3C3, 16'h0001, 16'h1234, arcl_pkg::OP_REQUEST));
        send_beat(make_arp(rand_link(), 16'h00F0, 16'h1234, 16'hFFFF));
        send_beat(make_arp(rand_link(), 16'h0F00, 16'h1234, 16'h0000));
        send_beat(make_xmit(16'h0001));
        send_beat(make_xmit(16'h0002));
        good = make_arp(rand_link(), 16'h0002, 16'h1234, arcl_pkg::OP_REQUEST);
        for (int k = 0; k < 7; k++) begin
            b = good;
            case (k)
                0: b.hw_type = 16'h0000;
                1: b.hw_type = 16'hFFFF;
                2: b.proto_type = 16'h0806;
                3: b.hw_len = 8'hFF;
                4: b.proto_len = 8'h00;
                5: b.sender_net = '0;
                default: b.target_net = '0;
            endcase
            send_beat(b);
        end
    endtask

    task automatic test_disable_switch();
        wait_idle();
        write_reg(arcl_pkg::CFG_ARP_DIS, arcl_pkg::CFG_W'(1));
        send_beat(make_arp(rand_link(), 16'h0BAD, cfg_my_net, arcl_pkg::OP_REQUEST));
        send_beat(make_xmit(16'h0001));
        wait_idle();
        write_reg(arcl_pkg::CFG_ARP_DIS, arcl_pkg::CFG_W'(0));
        send_beat(make_arp(rand_link(), 16'h0BAD, cfg_my_net, arcl_pkg::OP_REQUEST));
    endtask

    task automatic test_backpressure();
        refill_pool();
        tx_pacing_on = 1'b0;
        rx_hold_cycles = 400;
        repeat (15) send_beat(random_beat());
        tx_pacing_on = 1'b1;
    endtask

    task automatic run_phase(input logic [arcl_pkg::NET_W-1:0] net,
                             input logic [arcl_pkg::LINK_W-1:0] link,
                             input logic [15:0] proto, input logic dis, input bit pacing,
                             input int count);
        apply_settings(net, link, proto, dis);
        refill_pool();
        tx_pacing_on = pacing;
        rx_pacing_on = pacing;
        repeat (count) send_beat(random_beat());
        tx_pacing_on = 1'b1;
        rx_pacing_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_phase(16'h0001, '0, 16'h0800, 1'b0, 1'b1, 380);
        run_phase(16'hFFFF, arcl_pkg::LINK_BCAST, 16'hFFFF, 1'b0, 1'b1, 380);
        run_phase(nonzero_net(), rand_link(), 16'h0000, 1'b0, 1'b0, 300);
        run_phase(nonzero_net(), rand_link(), 16'($urandom), 1'b1, 1'b1, 100);
        run_phase(16'h0000, rand_link(), arcl_pkg::PROTO_RESET, 1'b0, 1'b1, 380);
    endtask

    initial begin : receiver_pacing
        int span;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                span = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_stall <= 1'b1;
            end else if (rx_pacing_on && $urandom_range(0, 3) == 0) begin
                span = gap_length() + 1;
                i_stall <= 1'b1;
            end else begin
                span = rx_pacing_on ? $urandom_range(1, 6) : 1;
                i_stall <= 1'b0;
            end
            repeat (span - 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_arcl_result seen;
        t_arcl_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_action, o_frame_dest_link, o_arp_target_link, o_arp_target_net,
                    o_cache_hit};
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with no outstanding input, act %0d dest %h",
                             $time, seen.action, seen.frame_dest);
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: expected act %0d dest %h tlink %h tnet %h hit %b",
                                 $time, want.action, want.frame_dest, want.target_link,
                                 want.target_net, want.cache_hit);
                        $display("%0t: actual   act %0d dest %h tlink %h tnet %h hit %b",
                                 $time, seen.action, seen.frame_dest, seen.target_link,
                                 seen.target_net, seen.cache_hit);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < arcl_pkg::ENTRIES; i++) begin
            cache_net[i] = '0;
            cache_link[i] = '0;
            cache_stamp[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) net_pool[i] = '0;
        use_count = FRESH_STAMP;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_disable_switch();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (arcl_pkg::ENTRIES + 4) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/arcl_pkg.sv
rtl/address_resolution_cache_lru_unit.sv
tb/address_resolution_cache_lru_unit_test.sv
